### hdl/nearest_point_to_segment_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest point to segment search unit
// Clock clk_i and active-low reset rst_ni are taken from the using module.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_TO_SEGMENT_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_POINT_TO_SEGMENT_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NPSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NPSS_ASSERT_NEVER(lbl, cond, msg) `NPSS_ASSERT(lbl, !(cond), msg)
`else
`define NPSS_ASSERT(lbl, prop, msg)
`define NPSS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/npss_pkg.sv
// ----------------------------------------------------------------------------
// npss_pkg
// Shared types and constants of the nearest point to segment search unit.
// ----------------------------------------------------------------------------
`default_nettype none
package npss_pkg;

  localparam int CoordW = 16;
  localparam int RelW   = CoordW + 1;
  localparam int IdW    = 10;
  localparam int DistW  = 40;
  localparam int LenW   = 36;
  localparam int TW     = 17;
  localparam logic [TW-1:0] T_ONE = 17'h10000;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_END_X   = 3'd3;
  localparam logic [2:0] REG_END_Y   = 3'd4;
  localparam logic [2:0] REG_END_Z   = 3'd5;
  localparam logic [2:0] REG_RADIUS  = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic [31:0]              radius_sqr;
  } npss_cfg_t;

  typedef struct packed {
    logic signed [RelW-1:0] rx;
    logic signed [RelW-1:0] ry;
    logic signed [RelW-1:0] rz;
    logic [IdW-1:0]         id;
    logic                   skip;
    logic                   last;
  } npss_entry_t;

endpackage
`default_nettype wire

### hdl/nearest_point_to_segment_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_to_segment_search_unit
// Nearest candidate point to a query segment, within a search radius.
//
//   channel  dir  handshake               payload
//   s_axis   in   tvalid/tready           tdata x,y,z,id; tuser skip; tlast
//   m_axis   out  tvalid/tready           tdata found,id,dist
//   cfg      in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// In the back, a skipped candidate goes straight to the decide step, and
// any other takes six shared multiply steps, up to sixteen radix-2 divider
// steps, six more multiply steps and one decide step; all multiply steps
// share the single multiplier. Reset clears control state and the running
// best; config registers reset to zero. A stalled result blocks the back
// only at the next scan end; front and queue take candidates till the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_point_to_segment_search_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // cand_x, cand_y, cand_z, cand_id, pad
  input  wire logic        s_axis_tuser,  // skip_entry
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // found, nearest_id, nearest_dist_sqr, pad
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  npss_pkg::npss_cfg_t   cfg;
  npss_pkg::npss_entry_t f_ent, q_ent;
  logic signed [15:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
  logic [15:0] rad_q;
  logic [31:0] rsq_q;
  logic f_push, q_ready, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
      ex_q  <= '0;
      ey_q  <= '0;
      ez_q  <= '0;
      rad_q <= '0;
      rsq_q <= '0;
    end else begin
      rsq_q <= rad_q * rad_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          npss_pkg::REG_START_X: sx_q  <= cfg_wdata_i;
          npss_pkg::REG_START_Y: sy_q  <= cfg_wdata_i;
          npss_pkg::REG_START_Z: sz_q  <= cfg_wdata_i;
          npss_pkg::REG_END_X:   ex_q  <= cfg_wdata_i;
          npss_pkg::REG_END_Y:   ey_q  <= cfg_wdata_i;
          npss_pkg::REG_END_Z:   ez_q  <= cfg_wdata_i;
          npss_pkg::REG_RADIUS:  rad_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign cfg.start_x    = sx_q;
  assign cfg.start_y    = sy_q;
  assign cfg.start_z    = sz_q;
  assign cfg.end_x      = ex_q;
  assign cfg.end_y      = ey_q;
  assign cfg.end_z      = ez_q;
  assign cfg.radius_sqr = rsq_q;

  npss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_skip_i    (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .push_o       (f_push),
    .push_ready_i (q_ready),
    .entry_o      (f_ent)
  );

  npss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_push),
    .push_ready_o (q_ready),
    .push_data_i  (f_ent),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_ent)
  );

  npss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_ent),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

### hdl/npss_front.sv
// ----------------------------------------------------------------------------
// npss_front
// Accepts candidate requests and forms their offset from the segment start.
// ----------------------------------------------------------------------------
`default_nettype none
module npss_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire npss_pkg::npss_cfg_t   cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [63:0]           in_data_i,
  input  wire logic                  in_skip_i,
  input  wire logic                  in_last_i,
  output logic                       push_o,
  input  wire logic                  push_ready_i,
  output npss_pkg::npss_entry_t      entry_o
);

  logic                  valid_q, valid_d;
  npss_pkg::npss_entry_t ent_q, ent_d;
  logic signed [npss_pkg::CoordW-1:0] px, py, pz;

  assign px = $signed(in_data_i[15:0]);
  assign py = $signed(in_data_i[31:16]);
  assign pz = $signed(in_data_i[47:32]);

  assign in_ready_o = !valid_q || push_ready_i;
  assign push_o     = valid_q;
  assign entry_o    = ent_q;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (in_ready_o) begin
      valid_d    = in_valid_i;
      ent_d.rx   = npss_pkg::RelW'(px) - npss_pkg::RelW'(cfg_i.start_x);
      ent_d.ry   = npss_pkg::RelW'(py) - npss_pkg::RelW'(cfg_i.start_y);
      ent_d.rz   = npss_pkg::RelW'(pz) - npss_pkg::RelW'(cfg_i.start_z);
      ent_d.id   = in_data_i[57:48];
      ent_d.skip = in_skip_i;
      ent_d.last = in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
`default_nettype wire

### hdl/npss_queue.sv
// ----------------------------------------------------------------------------
// npss_queue
// Small request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module npss_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       push_ready_o,
  input  wire npss_pkg::npss_entry_t push_data_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_i,
  output npss_pkg::npss_entry_t      pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  npss_pkg::npss_entry_t mem [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_data_i;
    end
  end

`include "nearest_point_to_segment_search_unit_assert.svh"

  `NPSS_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count exceeds depth")
  `NPSS_ASSERT_NEVER(a_pop_empty, pop_i && !pop_valid_o, "pop from empty queue")
  `NPSS_ASSERT(a_cnt_step, do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1,
               "queue count did not advance on push")

endmodule
`default_nettype wire

### hdl/npss_back.sv
// ----------------------------------------------------------------------------
// npss_back
// Sequencer: projection, radix-2 division, distance and running best.
// ----------------------------------------------------------------------------
`default_nettype none
module npss_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire npss_pkg::npss_cfg_t   cfg_i,
  input  wire logic                  q_valid_i,
  output logic                       q_pop_o,
  input  wire npss_pkg::npss_entry_t q_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [55:0]                out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_PROJ   = 3'd3;
  localparam logic [2:0] ST_DIST   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  localparam int RW = npss_pkg::RelW;
  localparam int OW = RW + 2;
  localparam int LW = npss_pkg::LenW;
  localparam int DW = npss_pkg::DistW;

  logic [2:0] st_q, st_d, ph_q, ph_d;
  logic [3:0] cnt_q, cnt_d;
  npss_pkg::npss_entry_t ent_q, ent_d;
  logic signed [DW-1:0] acc_q, acc_d, acc_sum;
  logic [LW-1:0]        len_q, len_d;
  logic [LW:0]          rem_q, rem_d, rem_sh;
  logic [npss_pkg::TW-1:0] t_q, t_d;
  logic signed [OW-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d, o_new;
  logic [DW-1:0]        dist_q, dist_d;
  logic signed [RW-1:0] dx, dy, dz, dsel, rsel;
  logic signed [OW-1:0] osel, mul_a, mul_b;
  logic signed [2*OW-1:0] prod;
  logic signed [RW:0]   fl;
  logic [DW-1:0]        best_dist_q, best_dist_d, thr, nb_dist;
  logic [npss_pkg::IdW-1:0] best_id_q, best_id_d, nb_id;
  logic                 best_valid_q, best_valid_d, nb_valid, upd;
  logic                 out_valid_q, out_valid_d;
  logic [55:0]          out_data_q, out_data_d;

  assign dx = RW'(cfg_i.end_x) - RW'(cfg_i.start_x);
  assign dy = RW'(cfg_i.end_y) - RW'(cfg_i.start_y);
  assign dz = RW'(cfg_i.end_z) - RW'(cfg_i.start_z);

  // axis select: phases 0..2 and 3..5 both walk x, y, z
  always_comb begin
    case (ph_q)
      3'd0, 3'd3: begin dsel = dx; rsel = ent_q.rx; osel = ox_q; end
      3'd1, 3'd4: begin dsel = dy; rsel = ent_q.ry; osel = oy_q; end
      3'd2, 3'd5: begin dsel = dz; rsel = ent_q.rz; osel = oz_q; end
      default:    begin dsel = dx; rsel = ent_q.rx; osel = ox_q; end
    endcase
  end

  // one shared multiplier
  always_comb begin
    case (st_q)
      ST_MAC: begin
        mul_a = (ph_q < 3'd3) ? OW'(dsel) : OW'(rsel);
        mul_b = OW'(dsel);
      end
      ST_PROJ: begin
        mul_a = OW'(dsel);
        mul_b = $signed({2'b00, t_q});
      end
      default: begin
        mul_a = osel;
        mul_b = osel;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_sum = acc_q + DW'(prod);
  assign fl      = $signed(prod[2*RW-1:16]);
  assign o_new   = OW'(rsel) - OW'(fl);
  assign rem_sh  = {rem_q[LW-1:0], 1'b0};

  assign thr      = best_valid_q ? best_dist_q : DW'(cfg_i.radius_sqr);
  assign upd      = !ent_q.skip && (dist_q <= thr);
  assign nb_valid = upd || best_valid_q;
  assign nb_id    = upd ? ent_q.id : best_id_q;
  assign nb_dist  = upd ? dist_q : best_dist_q;

  always_comb begin
    st_d         = st_q;
    ph_d         = ph_q;
    cnt_d        = cnt_q;
    ent_d        = ent_q;
    acc_d        = acc_q;
    len_d        = len_q;
    rem_d        = rem_q;
    t_d          = t_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    oz_d         = oz_q;
    dist_d       = dist_q;
    best_dist_d  = best_dist_q;
    best_id_d    = best_id_q;
    best_valid_d = best_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    q_pop_o      = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_data_i;
          acc_d   = '0;
          ph_d    = '0;
          st_d    = q_data_i.skip ? ST_DECIDE : ST_MAC;
        end
      end
      ST_MAC: begin
        ph_d  = ph_q + 1'b1;
        acc_d = acc_sum;
        if (ph_q == 3'd2) begin
          len_d = LW'(acc_sum);
          acc_d = '0;
        end else if (ph_q == 3'd5) begin
          ph_d = '0;
          st_d = ST_PROJ;
          if (len_q == '0 || acc_sum <= 0) begin
            t_d = '0;
          end else if (acc_sum >= $signed({4'b0000, len_q})) begin
            t_d = npss_pkg::T_ONE;
          end else begin
            rem_d = (LW + 1)'(acc_sum);
            t_d   = '0;
            cnt_d = '0;
            st_d  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (rem_sh >= {1'b0, len_q}) begin
          rem_d = rem_sh - {1'b0, len_q};
          t_d   = {t_q[npss_pkg::TW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          t_d   = {t_q[npss_pkg::TW-2:0], 1'b0};
        end
        if (cnt_q == 4'd15) begin
          st_d = ST_PROJ;
        end
      end
      ST_PROJ: begin
        ph_d = ph_q + 1'b1;
        case (ph_q)
          3'd0:    ox_d = o_new;
          3'd1:    oy_d = o_new;
          default: oz_d = o_new;
        endcase
        if (ph_q == 3'd2) begin
          ph_d  = '0;
          acc_d = '0;
          st_d  = ST_DIST;
        end
      end
      ST_DIST: begin
        ph_d  = ph_q + 1'b1;
        acc_d = acc_sum;
        if (ph_q == 3'd2) begin
          dist_d = DW'(acc_sum);
          st_d   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!ent_q.last) begin
          best_valid_d = nb_valid;
          best_id_d    = nb_id;
          best_dist_d  = nb_dist;
          st_d         = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // emit the scan result and clear the running best
          out_valid_d  = 1'b1;
          out_data_d   = {5'b0, nb_valid ? nb_dist : DW'(cfg_i.radius_sqr),
                          nb_valid ? nb_id : '0, nb_valid};
          best_valid_d = 1'b0;
          best_id_d    = '0;
          best_dist_d  = '0;
          st_d         = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      ph_q         <= '0;
      cnt_q        <= '0;
      t_q          <= '0;
      len_q        <= '0;
      best_valid_q <= 1'b0;
      best_id_q    <= '0;
      best_dist_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      ph_q         <= ph_d;
      cnt_q        <= cnt_d;
      t_q          <= t_d;
      len_q        <= len_d;
      best_valid_q <= best_valid_d;
      best_id_q    <= best_id_d;
      best_dist_q  <= best_dist_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    oz_q       <= oz_d;
    dist_q     <= dist_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "nearest_point_to_segment_search_unit_assert.svh"

  `NPSS_ASSERT(a_t_range, t_q <= npss_pkg::T_ONE, "projection parameter above one")
  `NPSS_ASSERT_NEVER(a_div_zero, st_q == ST_DIV && len_q == '0, "divide by zero length")
  `NPSS_ASSERT(a_emit_src, $rose(out_valid_q) |-> $past(st_q) == ST_DECIDE,
               "result raised outside decide step")

endmodule
`default_nettype wire
